// ===== src/lcd_frame_buffer_refresh_macros.svh =====
// Assertion macros used by the frame buffer checker.
`ifndef LCD_FRAME_BUFFER_REFRESH_MACROS_SVH
`define LCD_FRAME_BUFFER_REFRESH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LFB_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfb_pkg.sv =====
// Shared constants, codes and control types of the LCD frame buffer.
package lfb_pkg;

  localparam int COLUMNS        = 128;
  localparam int PAGES          = 8;
  localparam int CMD_STEPS      = 3;
  localparam int STEPS_PER_PAGE = COLUMNS + CMD_STEPS;
  localparam int STORE_DEPTH    = COLUMNS * PAGES;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int STEP_W = $clog2(STEPS_PER_PAGE);

  localparam int IN_W  = 24;
  localparam int OUT_W = 8;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    REQ_PLOT    = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_FILL    = 2'd2,
    REQ_TICK    = 2'd3
  } req_t;

  typedef struct packed {
    logic start;
    logic from_store;
    logic advance;
  } seq_ctl_t;

  typedef struct packed {
    logic              active;
    logic              is_data;
    logic              frame_end;
    logic              from_store;
    logic [7:0]        cmd_byte;
    logic [7:0]        held_fill;
    logic [ADDR_W-1:0] rd_addr;
  } seq_stat_t;

endpackage

// ===== src/lfb_frame_ram.sv =====
// Frame store: one write port, one registered read port.
module lfb_frame_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lfb_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic                      re,
  input  logic [lfb_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import lfb_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lfb_seq.sv =====
// Refresh sequencer: page and step counters, command bytes, read address.
module lfb_seq (
  input  logic               clk,
  input  logic               rst,
  input  lfb_pkg::seq_ctl_t  ctl,
  input  logic [7:0]         fill_value,
  output lfb_pkg::seq_stat_t stat
);
  import lfb_pkg::*;

  logic              active;
  logic              from_store;
  logic [7:0]        held_fill;
  logic [PAGE_W-1:0] page;
  logic [STEP_W-1:0] step;
  logic [COL_W-1:0]  col;
  logic [7:0]        cmd_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      from_store <= 1'b0;
      held_fill  <= 8'h00;
      page       <= '0;
      step       <= '0;
    end else if (ctl.start) begin
      active     <= 1'b1;
      from_store <= ctl.from_store;
      page       <= '0;
      step       <= '0;
      if (!ctl.from_store) begin
        held_fill <= fill_value;
      end
    end else if (ctl.advance) begin
      if (step == STEP_W'(STEPS_PER_PAGE - 1)) begin
        step <= '0;
        if (page == PAGE_W'(PAGES - 1)) begin
          page   <= '0;
          active <= 1'b0;
        end else begin
          page <= page + 1'b1;
        end
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  assign col = COL_W'(step - STEP_W'(CMD_STEPS));

  always_comb begin
    case (step)
      STEP_W'(0): cmd_byte = CMD_PAGE_BASE + 8'(page);
      STEP_W'(1): cmd_byte = CMD_COL_LOW;
      default:    cmd_byte = CMD_COL_HIGH;
    endcase
  end

  assign stat.cmd_byte   = cmd_byte;
  assign stat.active     = active;
  assign stat.from_store = from_store;
  assign stat.held_fill  = held_fill;
  assign stat.is_data    = (step >= STEP_W'(CMD_STEPS));
  assign stat.frame_end  = (page == PAGE_W'(PAGES - 1)) &&
                           (step == STEP_W'(STEPS_PER_PAGE - 1));
  assign stat.rd_addr    = ADDR_W'(ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col));

endmodule

// ===== src/lcd_frame_buffer_refresh.sv =====
// Top level of the page-mode monochrome LCD frame buffer with refresh sequencer.
//
//  channel | direction | tdata                                 | tuser    | tlast
//  --------+-----------+---------------------------------------+----------+----------
//  s_      | in        | row[5:0] column[12:6] pixel[13]       | req_type | -
//          |           | fill_value[21:14], zero pad [23:22]   |          |
//  m_      | out       | out_byte[7:0]                         | is_data  | frame_end
//
// After reset a clearing pass zeroes the store, one byte a cycle, over all STORE_DEPTH
// (1024) addresses, with s_tready low. A plot reads the byte, then ORs the pixel in
// and writes it back over the single write port of the store. A start, or a tick
// while the sequencer is idle, is taken in the idle state alone. An active tick
// reads the store, then loads the output register once m_tready lets it; a result
// held in m_ does not stop later plots or starts.
module lcd_frame_buffer_refresh (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [lfb_pkg::IN_W-1:0] s_tdata,   // row, column, pixel, fill_value, pad
  input  logic [1:0]               s_tuser,   // req_type
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [lfb_pkg::OUT_W-1:0] m_tdata,  // out_byte
  output logic                     m_tuser,   // is_data
  output logic                     m_tlast    // frame_end
);
  import lfb_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR    = 4'b0001,
    ST_IDLE     = 4'b0010,
    ST_PLOT_WR  = 4'b0100,
    ST_TICK_OUT = 4'b1000
  } state_t;

  state_t state, state_next;

  // Input fields.
  req_t        req;
  logic [5:0]  row;
  logic [6:0]  column;
  logic        pixel;
  logic [7:0]  fill_value;

  logic              accept;
  logic              plot_ok;
  logic [ADDR_W-1:0] plot_addr;
  logic [ADDR_W-1:0] plot_addr_q;
  logic [7:0]        plot_mask_q;
  logic [ADDR_W-1:0] clr_addr;

  // Store ports.
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  seq_ctl_t  seq_ctl;
  seq_stat_t seq_stat;
  logic      load_out;
  logic [7:0] out_byte;

  assign req        = req_t'(s_tuser);
  assign row        = s_tdata[5:0];
  assign column     = s_tdata[12:6];
  assign pixel      = s_tdata[13];
  assign fill_value = s_tdata[21:14];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Drop plots outside the panel.
  assign plot_ok   = (int'(row[5:3]) < PAGES) && (int'(column) < COLUMNS);
  assign plot_addr = ADDR_W'(ADDR_W'(row[5:3]) * ADDR_W'(COLUMNS) + ADDR_W'(column));

  always_ff @(posedge clk) begin
    if (accept) begin
      plot_addr_q <= plot_addr;
      plot_mask_q <= 8'(pixel) << row[2:0];
    end
  end

  // Clear pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_PLOT: begin
              if (plot_ok) begin
                state_next = ST_PLOT_WR;
              end
            end
            REQ_TICK: begin
              if (seq_stat.active) begin
                state_next = ST_TICK_OUT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PLOT_WR:  state_next = ST_IDLE;
      ST_TICK_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Write port: zeros during the clear pass, read-modify-write for a plot.
  always_comb begin
    we    = 1'b0;
    waddr = plot_addr_q;
    wdata = rdata | plot_mask_q;
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 8'h00;
    end else if (state == ST_PLOT_WR) begin
      we = 1'b1;
    end
  end

  // Read port: plot byte or the sequencer's current data byte.
  assign re    = accept;
  assign raddr = (req == REQ_PLOT) ? plot_addr : seq_stat.rd_addr;

  lfb_frame_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign seq_ctl.start      = accept && ((req == REQ_REFRESH) || (req == REQ_FILL));
  assign seq_ctl.from_store = (req == REQ_REFRESH);
  assign seq_ctl.advance    = load_out;

  lfb_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .ctl        (seq_ctl),
    .fill_value (fill_value),
    .stat       (seq_stat)
  );

  // Load the output register once it is free; the counters advance with it.
  assign load_out = (state == ST_TICK_OUT) && (!m_tvalid || m_tready);

  assign out_byte = seq_stat.is_data ? (seq_stat.from_store ? rdata : seq_stat.held_fill)
                                     : seq_stat.cmd_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_byte;
      m_tuser <= seq_stat.is_data;
      m_tlast <= seq_stat.frame_end;
    end
  end

endmodule

// ===== src/lfb_checker.sv =====
// Port-level checker for the LCD frame buffer and its bind to the top level.
`include "lcd_frame_buffer_refresh_macros.svh"

module lfb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [lfb_pkg::IN_W-1:0]  s_tdata,
  input logic [1:0]                s_tuser,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lfb_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser,
  input logic                      m_tlast
);

  // The frame end mark rides only on a data byte.
  `LFB_ASSERT_IMPL(a_end_on_data, clk, rst, m_tvalid && m_tlast, m_tuser, "frame_end on a command byte")

  // Command bytes are a page address or one of the two column bytes.
  `LFB_ASSERT_IMPL(a_cmd_form, clk, rst, m_tvalid && !m_tuser, (m_tdata == 8'h00) || (m_tdata == 8'h10) || (m_tdata[7:4] == 4'hB), "bad command byte")

  // A stalled result holds.
  `LFB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output changed")

  // A new result appears only after the input side has been closed.
  `LFB_ASSERT_IMPL(a_out_after_busy, clk, rst, $rose(m_tvalid), $past(!s_tready), "result without a busy cycle")

endmodule

bind lcd_frame_buffer_refresh lfb_checker u_lfb_checker (.*);
